>>> src/mgvb_pkg.sv
// Package with the types, codes and sine table function of the MIDI glide, vibrato and bend block.
`timescale 1ns / 1ps

package mgvb_pkg;

  localparam int SineDepthDef   = 256;
  localparam int SilenceBitsDef = 16;

  localparam logic [7:0]  StNoteOn   = 8'h90;
  localparam logic [7:0]  StNoteOff  = 8'h80;
  localparam logic [7:0]  StBend     = 8'he0;
  localparam logic [6:0]  CenterKey  = 7'd64;
  localparam logic [1:0]  MsgLen     = 2'd3;
  localparam logic [13:0] BendMax    = 14'h3fff;
  localparam logic [15:0] CoeffReset = 16'hffff;
  localparam logic [29:0] BendReset  = 30'h2000_0000;
  localparam logic [13:0] TargetReset = 14'h2000;
  localparam logic [7:0]  NoKey      = 8'd128;

  typedef enum logic [1:0] {
    CFG_GLISS_SEP   = 2'd0,
    CFG_GLIDE_COEFF = 2'd1,
    CFG_PHASE_STEP  = 2'd2,
    CFG_VIB_DEPTH   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic       action;
    logic [1:0] byte_count;
    logic [7:0] status_byte;
    logic [6:0] key_number;
    logic [6:0] velocity;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_status;
    logic [6:0] out_data_first;
    logic [6:0] out_data_second;
    logic       last_of_run;
  } out_item_t;

  // Sine of a 32-bit phase in Q1.15, from a quarter-wave odd polynomial in Q30.
  function automatic logic signed [15:0] sine_entry(input logic [63:0] u);
    logic [1:0]         quad;
    logic [63:0]        f;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        r;
    logic [63:0]        q;
    logic signed [15:0] v;
    quad = u[31:30];
    f    = {34'd0, u[29:0]};
    x    = quad[0] ? ((64'd1 << 30) - f) : f;
    x2   = (x * x) >> 30;
    r    = 64'd172272;
    r    = 64'd5026995 - ((r * x2) >> 30);
    r    = 64'd85569306 - ((r * x2) >> 30);
    r    = 64'd693598670 - ((r * x2) >> 30);
    r    = 64'd1686629713 - ((r * x2) >> 30);
    q    = (r * x) >> 30;
    q    = (q + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    v = $signed(q[15:0]);
    return quad[1] ? -v : v;
  endfunction

endpackage

>>> src/midi_glide_vibrato_bend.sv
// Top level of the MIDI glide, vibrato and pitch bend generator.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   in_data_i (in_item_t)
//   out      output     out_valid_o / out_ready_i out_data_o (out_item_t)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An item is taken every cycle unless the output backs up; it passes an input register, where
// the glide, phase and note state is updated, then a bend register, where the sine lookup and
// depth multiply finish, then a two-entry output queue. A result is valid once it is in the
// queue.
// A tick that also releases a note makes two results; it waits in the bend register only
// while the queue has no room for both.
// Reset restores the control, note and config state at once, with no clearing pass.
// A stalled output fills the queue and then stops the input.
`timescale 1ns / 1ps

module midi_glide_vibrato_bend #(
  parameter int SINE_TABLE_DEPTH = mgvb_pkg::SineDepthDef,
  parameter int SILENCE_BITS     = mgvb_pkg::SilenceBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mgvb_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mgvb_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import mgvb_pkg::*;

  localparam int IdxW  = $clog2(SINE_TABLE_DEPTH);
  localparam int ProdW = 32 + IdxW;
  localparam int CmpW  = (SILENCE_BITS > 16) ? SILENCE_BITS : 16;

  // Sine table.
  logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
    localparam logic [63:0] PhaseU = (64'(k) << 32) / SINE_TABLE_DEPTH;
    assign sine_rom[k] = sine_entry(PhaseU);
  end

  // Configuration registers.
  logic [15:0] sep_q;
  logic [15:0] coeff_q;
  logic [31:0] step_q;
  logic [12:0] depth_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= '0;
      coeff_q <= CoeffReset;
      step_q  <= '0;
      depth_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_GLISS_SEP:   sep_q   <= cfg_data_i[15:0];
        CFG_GLIDE_COEFF: coeff_q <= cfg_data_i[15:0];
        CFG_PHASE_STEP:  step_q  <= cfg_data_i;
        CFG_VIB_DEPTH:   depth_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Input register and note state.
  logic                    a_vld_q;
  in_item_t                a_q;
  logic [29:0]             cur_q;
  logic [13:0]             target_q;
  logic [31:0]             phase_q;
  logic [SILENCE_BITS-1:0] sil_q;
  logic [7:0]              held_q;
  logic                    pend_q;
  logic [7:0]              rel_status_q;
  logic [6:0]              rel_vel_q;

  logic                    b_ready;
  logic                    a_fire;
  logic                    is_tick;
  logic                    is_msg;
  logic                    note_on;
  logic                    note_off;
  logic [SILENCE_BITS-1:0] sil_tick;
  logic                    rel_fire;
  logic                    jump;
  logic [31:0]             phase_new;
  logic [46:0]             glide_keep;
  logic [29:0]             glide_pull;
  logic [29:0]             cur_glide;
  logic [ProdW-1:0]        idx_prod;

  assign in_ready_o = !a_vld_q || b_ready;
  assign a_fire     = a_vld_q && b_ready;

  always_comb begin
    is_tick   = a_q.action;
    is_msg    = !a_q.action && (a_q.byte_count == MsgLen);
    note_on   = is_msg && (a_q.status_byte == StNoteOn) && (a_q.velocity != 7'd0);
    note_off  = is_msg && !note_on && (held_q == {1'b0, a_q.key_number})
                && ((a_q.status_byte == StNoteOn) || (a_q.status_byte == StNoteOff));
    sil_tick  = (pend_q && (sil_q != '1)) ? sil_q + 1'b1 : sil_q;
    rel_fire  = is_tick && pend_q && (CmpW'(sil_tick) > CmpW'(sep_q));
    jump      = note_on && (CmpW'(sil_q) > CmpW'(sep_q));
    phase_new = phase_q + step_q;
    glide_keep = 47'(cur_q) * 47'(17'h10000 - {1'b0, coeff_q});
    glide_pull = 30'(target_q) * 30'(coeff_q);
    cur_glide  = glide_keep[45:16] + glide_pull;
    idx_prod   = ProdW'(phase_new) * ProdW'(SINE_TABLE_DEPTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q      <= 1'b0;
      cur_q        <= BendReset;
      target_q     <= TargetReset;
      phase_q      <= '0;
      sil_q        <= '1;
      held_q       <= NoKey;
      pend_q       <= 1'b0;
      rel_status_q <= '0;
      rel_vel_q    <= '0;
    end else begin
      if (in_ready_o) begin
        a_vld_q <= in_valid_i;
      end
      if (a_fire) begin
        if (is_tick) begin
          sil_q   <= sil_tick;
          phase_q <= phase_new;
          cur_q   <= cur_glide;
          if (rel_fire) begin
            pend_q <= 1'b0;
          end
        end else if (note_on) begin
          target_q <= {a_q.key_number, 7'd0};
          if (jump) begin
            cur_q <= {a_q.key_number, 23'd0};
          end
          held_q <= {1'b0, a_q.key_number};
          pend_q <= 1'b0;
          sil_q  <= '0;
        end else if (note_off) begin
          pend_q       <= 1'b1;
          rel_status_q <= a_q.status_byte;
          rel_vel_q    <= a_q.velocity;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_q <= in_data_i;
    end
  end

  // Bend register.
  logic            b_vld_q;
  logic            b_pre_q;
  logic [7:0]      b_status_q;
  logic [6:0]      b_vel_q;
  logic            b_tick_q;
  logic [13:0]     b_hi_q;
  logic [IdxW-1:0] b_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_ready) begin
      b_vld_q <= a_fire && (is_tick || jump);
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_pre_q    <= rel_fire || jump;
      b_status_q <= rel_fire ? rel_status_q : a_q.status_byte;
      b_vel_q    <= rel_fire ? rel_vel_q : a_q.velocity;
      b_tick_q   <= is_tick;
      b_hi_q     <= cur_glide[29:16];
      b_idx_q    <= idx_prod[ProdW-1 -: IdxW];
    end
  end

  logic signed [15:0] sine_val;
  logic signed [29:0] vib_prod;
  logic signed [30:0] vib_round;
  logic signed [15:0] dev;
  logic signed [16:0] bend_sum;
  logic [13:0]        bend;
  out_item_t          msg [2];
  logic [1:0]         need;

  always_comb begin
    sine_val  = sine_rom[b_idx_q];
    vib_prod  = 30'($signed({1'b0, depth_q})) * 30'(sine_val);
    vib_round = 31'(vib_prod) + 31'sd16384;
    dev       = 16'(vib_round >>> 15);
    bend_sum  = $signed({3'b000, b_hi_q}) + 17'(dev);
    if (bend_sum < 0) begin
      bend = '0;
    end else if (bend_sum > $signed({3'b000, BendMax})) begin
      bend = BendMax;
    end else begin
      bend = bend_sum[13:0];
    end

    msg[0] = '{out_status: b_status_q, out_data_first: CenterKey,
               out_data_second: b_vel_q, last_of_run: !b_tick_q};
    msg[1] = '{out_status: StBend, out_data_first: bend[6:0],
               out_data_second: bend[13:7], last_of_run: 1'b1};
    if (!b_pre_q) begin
      msg[0] = msg[1];
    end
    need = {1'b0, b_pre_q} + {1'b0, b_tick_q};
  end

  // Output queue.
  out_item_t  q_q [2];
  logic [1:0] cnt_q;
  out_item_t  q_d [2];
  logic [1:0] cnt_d;
  logic       pop;
  logic       b_push;
  logic [1:0] base;
  logic [1:0] room;
  logic [1:0] slot;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = q_q[0];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    room    = 2'd2 - cnt_q + {1'b0, pop};
    b_push  = b_vld_q && (room >= need);
    b_ready = !b_vld_q || b_push;
    base    = cnt_q - {1'b0, pop};
    q_d     = q_q;
    if (pop) begin
      q_d[0] = q_q[1];
    end
    for (int i = 0; i < 2; i++) begin
      slot = 2'(i) - base;
      if (b_push && (2'(i) >= base) && (slot < need)) begin
        q_d[i] = msg[slot[0]];
      end
    end
    cnt_d = base + (b_push ? need : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

endmodule
